// ===== rtl/tbws_pkg.sv =====
// shared types and constants for the timed bounce/wrap sequencer
package tbws_pkg;

  // field widths of the stream words
  localparam int TIME_BITS   = 64;
  localparam int ID_BITS     = 8;
  localparam int EMIT_BITS   = 16;
  localparam int BOUND_BITS  = 16;
  localparam int STEP_BITS   = 8;
  localparam int IVAL_BITS   = 32;
  localparam int IN_BITS     = 72;
  localparam int OUT_BITS    = 48;

  // configuration port geometry
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;

  // register map, index is the word address
  typedef enum logic [2:0] {
    REG_INTERVAL  = 3'd0,
    REG_STEP      = 3'd1,
    REG_START     = 3'd2,
    REG_END       = 3'd3,
    REG_BOUNCE    = 3'd4,
    REG_UNIFORM   = 3'd5,
    REG_INIT_ASC  = 3'd6
  } tbws_reg_t;

  // register reset values
  localparam logic [IVAL_BITS-1:0]  RST_INTERVAL = 32'd0;
  localparam logic [STEP_BITS-1:0]  RST_STEP     = 8'sd1;
  localparam logic [BOUND_BITS-1:0] RST_START    = 16'sd0;
  localparam logic [BOUND_BITS-1:0] RST_END      = 16'sd255;

endpackage

// ===== rtl/timed_bounce_wrap_sequencer.sv =====
// timed bounce/wrap sequencer: input register, step logic, result register
// a word that steps is held in the input register, and its result is then
//   registered in the result register; a stalled output can hold it in between
// throughput: one word per cycle unless the output stalls; the state loop (elapsed
//   compare, value add and bound compare) closes within the step stage
// a word whose interval has not elapsed leaves without a result
// reset: synchronous active-low rst_n clears both stages and loads register defaults
module timed_bounce_wrap_sequencer #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: now_time[63:0], sequence_id[71:64]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tbws_pkg::IN_BITS-1:0]        in_tdata,
  // out_tdata: seq_id_out[7:0], emitted_value[23:8], prior_value[39:24],
  //   toggle_flag[40], going_up[41], zero fill[47:42]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tbws_pkg::OUT_BITS-1:0]       out_tdata,
  // apb-style configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tbws_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [tbws_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [tbws_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                                cfg_pready
);
  import tbws_pkg::*;

  // compare width holds the value, the bounds and a one-step adjustment
  localparam int CW = ((VALUE_BITS > BOUND_BITS) ? VALUE_BITS : BOUND_BITS) + 2;

  // configuration registers
  logic [IVAL_BITS-1:0]  interval_r;
  logic [STEP_BITS-1:0]  step_r;
  logic [BOUND_BITS-1:0] start_r;
  logic [BOUND_BITS-1:0] end_r;
  logic                  bounce_r;
  logic                  uniform_r;
  logic                  init_asc_r;

  // sequencer state
  logic [TIME_BITS-1:0]  last_refresh_r;
  logic [VALUE_BITS-1:0] seq_value_r, seq_value_nxt;
  logic [VALUE_BITS-1:0] last_value_r;
  logic                  ascending_r, ascending_nxt;
  logic                  toggled_r, toggled_nxt;

  // input stage
  logic                  s1_valid_r;
  logic [TIME_BITS-1:0]  s1_time_r;
  logic [ID_BITS-1:0]    s1_id_r;

  // result stage
  logic                  out_valid_r;
  logic [OUT_BITS-1:0]   out_data_r;

  logic cfg_wr;
  logic due;
  logic consume;
  logic step_fire;
  logic [TIME_BITS-1:0] elapsed;

  logic signed [CW-1:0]  start_x, end_x, step_x, seq_x, last_x, v_x;
  logic signed [CW-1:0]  hi_lim, lo_lim;
  logic signed [CW-1:0]  start_wr_x;
  logic [VALUE_BITS-1:0] start_v, end_v, step_v, v_raw;
  logic                  over_hi, under_lo;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register read back
  always_comb begin
    cfg_prdata = '0;
    case (tbws_reg_t'(cfg_paddr[4:2]))
      REG_INTERVAL: cfg_prdata = interval_r;
      REG_STEP:     cfg_prdata = {{(CFG_DATA_BITS-STEP_BITS){1'b0}}, step_r};
      REG_START:    cfg_prdata = {{(CFG_DATA_BITS-BOUND_BITS){1'b0}}, start_r};
      REG_END:      cfg_prdata = {{(CFG_DATA_BITS-BOUND_BITS){1'b0}}, end_r};
      REG_BOUNCE:   cfg_prdata = {{(CFG_DATA_BITS-1){1'b0}}, bounce_r};
      REG_UNIFORM:  cfg_prdata = {{(CFG_DATA_BITS-1){1'b0}}, uniform_r};
      REG_INIT_ASC: cfg_prdata = {{(CFG_DATA_BITS-1){1'b0}}, init_asc_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // interval check on the registered time stamp
  assign elapsed = s1_time_r - last_refresh_r;
  assign due     = !(elapsed < {{(TIME_BITS-IVAL_BITS){1'b0}}, interval_r});

  // handshake: a word without a result never waits for the output side
  assign step_fire = s1_valid_r & due & (!out_valid_r | out_tready);
  assign consume   = s1_valid_r & (!due | !out_valid_r | out_tready);
  assign in_tready = !s1_valid_r | consume;

  // sign-extended operands
  assign start_x = {{(CW-BOUND_BITS){start_r[BOUND_BITS-1]}}, start_r};
  assign end_x   = {{(CW-BOUND_BITS){end_r[BOUND_BITS-1]}}, end_r};
  assign step_x  = {{(CW-STEP_BITS){step_r[STEP_BITS-1]}}, step_r};
  assign seq_x   = {{(CW-VALUE_BITS){seq_value_r[VALUE_BITS-1]}}, seq_value_r};
  assign last_x  = {{(CW-VALUE_BITS){last_value_r[VALUE_BITS-1]}}, last_value_r};
  assign start_v = start_x[VALUE_BITS-1:0];
  assign end_v   = end_x[VALUE_BITS-1:0];
  assign step_v  = step_x[VALUE_BITS-1:0];

  // start bound being written, sign-extended from the bound width
  assign start_wr_x = {{(CW-BOUND_BITS){cfg_pwdata[BOUND_BITS-1]}},
                       cfg_pwdata[BOUND_BITS-1:0]};

  // step the value, wrapping at the value width
  assign v_raw = ascending_r ? (seq_value_r + step_v) : (seq_value_r - step_v);
  assign v_x   = {{(CW-VALUE_BITS){v_raw[VALUE_BITS-1]}}, v_raw};

  // limits, pulled in by one in bounce mode with uniform ends
  assign hi_lim   = (bounce_r && uniform_r) ? (end_x - CW'(1)) : end_x;
  assign lo_lim   = (bounce_r && uniform_r) ? (start_x + CW'(1)) : start_x;
  assign over_hi  = v_x > hi_lim;
  assign under_lo = v_x < lo_lim;

  // bound handling
  always_comb begin
    seq_value_nxt = v_raw;
    ascending_nxt = ascending_r;
    toggled_nxt   = toggled_r;
    if (ascending_r && over_hi) begin
      seq_value_nxt = bounce_r ? end_v : start_v;
      ascending_nxt = !bounce_r;
      toggled_nxt   = !toggled_r;
    end else if (!ascending_r && under_lo) begin
      seq_value_nxt = bounce_r ? start_v : end_v;
      ascending_nxt = bounce_r;
      toggled_nxt   = !toggled_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RST_INTERVAL;
      step_r     <= RST_STEP;
      start_r    <= RST_START;
      end_r      <= RST_END;
      bounce_r   <= 1'b0;
      uniform_r  <= 1'b0;
      init_asc_r <= 1'b1;
    end else if (cfg_wr) begin
      case (tbws_reg_t'(cfg_paddr[4:2]))
        REG_INTERVAL: interval_r <= cfg_pwdata;
        REG_STEP:     step_r     <= cfg_pwdata[STEP_BITS-1:0];
        REG_START:    start_r    <= cfg_pwdata[BOUND_BITS-1:0];
        REG_END:      end_r      <= cfg_pwdata[BOUND_BITS-1:0];
        REG_BOUNCE:   bounce_r   <= cfg_pwdata[0];
        REG_UNIFORM:  uniform_r  <= cfg_pwdata[0];
        REG_INIT_ASC: init_asc_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // sequencer state: a valid write reloads direction and value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_refresh_r <= '0;
      seq_value_r    <= '0;
      last_value_r   <= '0;
      ascending_r    <= 1'b1;
      toggled_r      <= 1'b0;
    end else if (cfg_wr) begin
      case (tbws_reg_t'(cfg_paddr[4:2]))
        REG_INTERVAL, REG_STEP, REG_END, REG_BOUNCE, REG_UNIFORM: begin
          ascending_r <= init_asc_r;
          seq_value_r <= start_v;
        end
        REG_START: begin
          ascending_r <= init_asc_r;
          seq_value_r <= start_wr_x[VALUE_BITS-1:0];
        end
        REG_INIT_ASC: begin
          ascending_r <= cfg_pwdata[0];
          seq_value_r <= start_v;
        end
        default: ;
      endcase
    end else if (step_fire) begin
      last_refresh_r <= s1_time_r;
      last_value_r   <= seq_value_r;
      seq_value_r    <= seq_value_nxt;
      ascending_r    <= ascending_nxt;
      toggled_r      <= toggled_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_time_r <= in_tdata[TIME_BITS-1:0];
      s1_id_r   <= in_tdata[TIME_BITS+ID_BITS-1:TIME_BITS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_data_r <= {6'b0, ascending_r, toggled_r, last_x[EMIT_BITS-1:0],
                     seq_x[EMIT_BITS-1:0], s1_id_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a result word must not be overwritten while it is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !step_fire)
    else $error("result overwritten while stalled");

  // the previous value follows the current value on each step
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && !cfg_wr) |=> (last_value_r == $past(seq_value_r)))
    else $error("prior value not taken from current value");

  // toggle and refresh time move only on a step
  a_toggle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_fire |=> ($stable(toggled_r) && $stable(last_refresh_r)))
    else $error("toggle or refresh time changed without a step");

endmodule
